/* design/gha_pkg.sv */
// Package for the generational handle allocator.
// Holds default sizes, request/status codes and the control state type.
// No dependencies.
package gha_pkg;

    // Default slot index and generation widths
    localparam int unsigned INDEX_BITS_DEF = 10;
    localparam int unsigned GEN_BITS_DEF   = 12;

    // Layer tag width and its reset value
    localparam int unsigned LAYER_BITS = 16;
    localparam logic [LAYER_BITS-1:0] LAYER_RESET = 16'd1;

    // Request codes
    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_CLEAN  = 2'd3
    } req_type_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_OUT_RANGE = 2'd3
    } status_t;

    // Control sequencer states
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_state_t;

endpackage

/* design/gha_if.sv */
// Request and response channel interfaces of the handle allocator.
// Depends on gha_pkg for request and status codes.

interface gha_req_if #(
    parameter int unsigned INDEX_BITS = gha_pkg::INDEX_BITS_DEF,
    parameter int unsigned GEN_BITS   = gha_pkg::GEN_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    gha_pkg::req_type_t              req_type;
    logic [gha_pkg::LAYER_BITS-1:0]  handle_layer;
    logic [INDEX_BITS-1:0]           handle_index;
    logic [GEN_BITS-1:0]             handle_generation;
    logic                            clean_remove;
    logic                            clean_last;

    modport source (
        output valid, req_type, handle_layer, handle_index, handle_generation,
               clean_remove, clean_last,
        input  ready
    );
    modport sink (
        input  valid, req_type, handle_layer, handle_index, handle_generation,
               clean_remove, clean_last,
        output ready
    );
endinterface

interface gha_rsp_if #(
    parameter int unsigned INDEX_BITS = gha_pkg::INDEX_BITS_DEF,
    parameter int unsigned GEN_BITS   = gha_pkg::GEN_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    gha_pkg::status_t      status;
    logic                  is_valid;
    logic [INDEX_BITS-1:0] new_index;
    logic [GEN_BITS-1:0]   new_generation;
    logic [INDEX_BITS:0]   used_count;
    logic                  needs_clean;

    modport source (
        output valid, status, is_valid, new_index, new_generation, used_count,
               needs_clean,
        input  ready
    );
    modport sink (
        input  valid, status, is_valid, new_index, new_generation, used_count,
               needs_clean,
        output ready
    );
endinterface

/* design/gha_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Takes its default sizes from gha_pkg; contents are not reset.
module gha_ram #(
    parameter int unsigned ADDR_BITS = gha_pkg::INDEX_BITS_DEF,
    parameter int unsigned DATA_BITS = gha_pkg::GEN_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/generational_handle_allocator.sv */
// The result register loads at the end of the execute state, which follows accept.
// A new request is taken only in idle, once the last one has executed; the slot memory
// read-modify-write (read issued at accept, write-back in the execute cycle) requires that.
// A waiting result does not block the next request; a full output stalls execute.
// Reset clears counters, free-list pointers and flags; slot memories are not cleared.
module generational_handle_allocator #(
    parameter int unsigned INDEX_BITS = gha_pkg::INDEX_BITS_DEF,
    parameter int unsigned GEN_BITS   = gha_pkg::GEN_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gha_pkg::LAYER_BITS-1:0] cfg_wdata,
    gha_req_if.sink                        req,
    gha_rsp_if.source                      rsp
);

    localparam int unsigned CNT_BITS = INDEX_BITS + 1;
    localparam int unsigned GW       = GEN_BITS + 1;
    localparam logic [CNT_BITS-1:0] SLOT_CAP = CNT_BITS'(1) << INDEX_BITS;

    // Control and bookkeeping registers
    gha_pkg::fsm_state_t state_reg, state_next;
    logic [gha_pkg::LAYER_BITS-1:0] layer_tag_reg;
    logic [CNT_BITS-1:0]   alloc_reg, alloc_next;
    logic [CNT_BITS-1:0]   free_cnt_reg, free_cnt_next;
    logic [INDEX_BITS-1:0] head_reg, head_next;
    logic [INDEX_BITS-1:0] tail_reg, tail_next;
    logic                  empty_reg, empty_next;
    logic                  pending_reg, pending_next;

    // Latched request payload
    gha_pkg::req_type_t             op_reg;
    logic [gha_pkg::LAYER_BITS-1:0] layer_reg;
    logic [INDEX_BITS-1:0]          idx_reg;
    logic [GEN_BITS-1:0]            gen_reg;
    logic                           crem_reg;
    logic                           clast_reg;

    // Output register
    logic                  rsp_valid_reg;
    gha_pkg::status_t      status_reg, status_next;
    logic                  is_valid_reg, is_valid_next;
    logic [INDEX_BITS-1:0] nidx_reg, nidx_next;
    logic [GEN_BITS-1:0]   ngen_reg, ngen_next;
    logic [CNT_BITS-1:0]   used_reg, used_next;
    logic                  clean_reg;

    // Memory ports
    logic                  rd_en;
    logic [INDEX_BITS-1:0] gen_raddr;
    logic [GW-1:0]         gen_rd;
    logic                  gen_we;
    logic [INDEX_BITS-1:0] gen_waddr;
    logic [GW-1:0]         gen_wdata;
    logic [INDEX_BITS-1:0] nf_rd;
    logic                  nf_we;

    logic                  accept;
    logic                  rsp_load;
    logic [GW-1:0]         gen_inc;
    logic                  idx_ok;
    logic                  handle_ok;
    logic                  do_queue;

    // Slot generation store: generation plus retired bit
    gha_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (GW)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (rd_en),
        .raddr (gen_raddr),
        .rdata (gen_rd)
    );

    // Free-list links: written at the old tail, read at the head
    gha_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (INDEX_BITS)
    ) u_link_ram (
        .clk   (clk),
        .we    (nf_we),
        .waddr (tail_reg),
        .wdata (idx_reg),
        .re    (rd_en),
        .raddr (head_reg),
        .rdata (nf_rd)
    );

    // Issue memory reads on accept
    assign accept    = req.valid && req.ready;
    assign rd_en     = accept;
    assign gen_raddr = (req.req_type == gha_pkg::REQ_CREATE) ? head_reg : req.handle_index;

    // Sequencer: next state and handshake
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        rsp_load   = 1'b0;
        unique case (state_reg)
            gha_pkg::FSM_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = gha_pkg::FSM_EXEC;
                end
            end
            gha_pkg::FSM_EXEC:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = gha_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = gha_pkg::FSM_IDLE;
            end
        endcase
    end

    // Handle check against the generation read for this request
    assign gen_inc   = gen_rd + GW'(1);
    assign idx_ok    = {1'b0, idx_reg} < alloc_reg;
    assign handle_ok = (layer_reg == layer_tag_reg) && idx_ok && (gen_rd == {1'b0, gen_reg});

    // Execute: update bookkeeping, write back memories, form the result
    always_comb
    begin
        alloc_next    = alloc_reg;
        free_cnt_next = free_cnt_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        pending_next  = pending_reg;
        status_next   = gha_pkg::ST_OK;
        is_valid_next = 1'b0;
        nidx_next     = '0;
        ngen_next     = '0;
        gen_we        = 1'b0;
        gen_waddr     = idx_reg;
        gen_wdata     = gen_inc;
        nf_we         = 1'b0;
        do_queue      = 1'b0;

        unique case (op_reg)
            gha_pkg::REQ_CREATE:
            begin
                priority if (!empty_reg)
                begin
                    // Pop the free-list head
                    nidx_next = head_reg;
                    ngen_next = gen_rd[GEN_BITS-1:0];
                    if (head_reg == tail_reg)
                    begin
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        head_next = nf_rd;
                    end
                    if (free_cnt_reg != '0)
                    begin
                        free_cnt_next = free_cnt_reg - CNT_BITS'(1);
                    end
                end
                else if (alloc_reg < SLOT_CAP)
                begin
                    // Append a fresh slot at generation 1
                    nidx_next  = alloc_reg[INDEX_BITS-1:0];
                    ngen_next  = GEN_BITS'(1);
                    gen_we     = rsp_load;
                    gen_waddr  = alloc_reg[INDEX_BITS-1:0];
                    gen_wdata  = GW'(1);
                    alloc_next = alloc_reg + CNT_BITS'(1);
                end
                else
                begin
                    status_next = gha_pkg::ST_FULL;
                end
            end
            gha_pkg::REQ_REMOVE:
            begin
                if (handle_ok)
                begin
                    do_queue     = 1'b1;
                    pending_next = 1'b1;
                end
                else
                begin
                    status_next = gha_pkg::ST_INVALID;
                end
            end
            gha_pkg::REQ_QUERY:
            begin
                is_valid_next = handle_ok;
            end
            gha_pkg::REQ_CLEAN:
            begin
                if (crem_reg)
                begin
                    if (!idx_ok)
                    begin
                        status_next = gha_pkg::ST_OUT_RANGE;
                    end
                    else if (!gen_rd[GEN_BITS])
                    begin
                        do_queue = 1'b1;
                    end
                end
                if (clast_reg)
                begin
                    pending_next = 1'b0;
                end
            end
            default:
            begin
                status_next = gha_pkg::ST_OK;
            end
        endcase

        // Bump the generation; queue at the tail unless it retires
        if (do_queue)
        begin
            gen_we = rsp_load;
            if (!gen_inc[GEN_BITS])
            begin
                if (empty_reg)
                begin
                    head_next = idx_reg;
                end
                else
                begin
                    nf_we = rsp_load;
                end
                tail_next  = idx_reg;
                empty_next = 1'b0;
                if (free_cnt_reg < SLOT_CAP)
                begin
                    free_cnt_next = free_cnt_reg + CNT_BITS'(1);
                end
            end
        end

        used_next = (alloc_next > free_cnt_next) ? (alloc_next - free_cnt_next) : '0;
    end

    // Hold sequencer state and free-list bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gha_pkg::FSM_IDLE;
            layer_tag_reg <= gha_pkg::LAYER_RESET;
            alloc_reg     <= '0;
            free_cnt_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            pending_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                layer_tag_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                alloc_reg    <= alloc_next;
                free_cnt_reg <= free_cnt_next;
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                empty_reg    <= empty_next;
                pending_reg  <= pending_next;
            end
            // Advance the output valid
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.req_type;
            layer_reg <= req.handle_layer;
            idx_reg   <= req.handle_index;
            gen_reg   <= req.handle_generation;
            crem_reg  <= req.clean_remove;
            clast_reg <= req.clean_last;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            status_reg   <= status_next;
            is_valid_reg <= is_valid_next;
            nidx_reg     <= nidx_next;
            ngen_reg     <= ngen_next;
            used_reg     <= used_next;
            clean_reg    <= pending_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.is_valid       = is_valid_reg;
    assign rsp.new_index      = nidx_reg;
    assign rsp.new_generation = ngen_reg;
    assign rsp.used_count     = used_reg;
    assign rsp.needs_clean    = clean_reg;

    // Memories are written only while a request executes
    assert property (@(posedge clk) disable iff (!rst_n)
        (gen_we || nf_we) |-> (state_reg == gha_pkg::FSM_EXEC && rsp_load))
        else $error("slot memory written outside execute");

    // An accepted request executes in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == gha_pkg::FSM_EXEC))
        else $error("accepted request did not reach execute");

    // Allocated slot count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg <= SLOT_CAP)
        else $error("allocated count beyond capacity");

    // Free count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= SLOT_CAP)
        else $error("free count beyond capacity");

endmodule

/* dv/tb_generational_handle_allocator.sv */
// Testbench for the generational handle allocator: directed and random requests are
// scored against an in-bench model of the slot table, the free list and the flags.
// Depends on gha_pkg, gha_if.sv and generational_handle_allocator.sv.
module tb_generational_handle_allocator;

    localparam int unsigned IB          = gha_pkg::INDEX_BITS_DEF;
    localparam int unsigned GB          = gha_pkg::GEN_BITS_DEF;
    localparam int unsigned LB          = gha_pkg::LAYER_BITS;
    localparam int unsigned SLOTS       = 1 << IB;
    localparam int unsigned RETIRED     = 1 << GB;
    localparam int unsigned STALL_LIMIT = 400;
    localparam int unsigned N_OPENING   = 22;

    typedef struct packed {
        gha_pkg::req_type_t kind;
        logic [LB-1:0]      layer;
        logic [IB-1:0]      index;
        logic [GB-1:0]      gen;
        logic               clean_rm;
        logic               clean_end;
    } alloc_req_t;

    typedef struct packed {
        gha_pkg::status_t status;
        logic             is_valid;
        logic [IB-1:0]    new_index;
        logic [GB-1:0]    new_gen;
        logic [IB:0]      used;
        logic             needs_clean;
    } alloc_rsp_t;

    typedef struct packed {
        logic [IB-1:0] index;
        logic [GB-1:0] gen;
    } slot_handle_t;

    // One opening request, with its result typed in when pinned is set
    typedef struct packed {
        gha_pkg::req_type_t kind;
        logic [LB-1:0]      layer;
        logic [IB-1:0]      index;
        logic [GB-1:0]      gen;
        logic               clean_rm;
        logic               clean_end;
        logic               pinned;
        gha_pkg::status_t   st;
        logic               vld;
        logic [IB-1:0]      nidx;
        logic [GB-1:0]      ngen;
        logic [IB:0]        used;
        logic               nc;
    } plan_row_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [LB-1:0] cfg_wdata;

    gha_req_if req_ch ();
    gha_rsp_if rsp_ch ();

    generational_handle_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Slot table image: generations, free-list links, counters and flags
    bit [GB:0]     gen_mem  [SLOTS];
    bit [IB-1:0]   next_mem [SLOTS];
    int unsigned   alloc_cnt  = 0;
    int unsigned   free_cnt   = 0;
    int unsigned   free_head  = 0;
    int unsigned   free_tail  = 0;
    bit            list_empty = 1'b1;
    bit            clean_due  = 1'b0;
    logic [LB-1:0] tag_q      = gha_pkg::LAYER_RESET;

    alloc_rsp_t   expected [$];
    slot_handle_t issued   [$];
    int unsigned  errors  = 0;
    bit           idle_ok = 1'b1;

    // Opening requests, straight after reset with the reset layer tag
    plan_row_t opening [N_OPENING] = '{
        // nothing allocated yet: query misses, remove fails, clean is out of range
        '{gha_pkg::REQ_QUERY, 16'h0001, 10'd0, 12'd0, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        '{gha_pkg::REQ_REMOVE, 16'h0001, 10'd0, 12'd1, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_INVALID, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        '{gha_pkg::REQ_CLEAN, 16'h0001, 10'd0, 12'd0, 1'b1, 1'b0,
          1'b1, gha_pkg::ST_OUT_RANGE, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        // fresh slots come out with generation 1
        '{gha_pkg::REQ_CREATE, 16'h0000, 10'd0, 12'd0, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd1, 11'd1, 1'b0},
        '{gha_pkg::REQ_CREATE, 16'h0000, 10'd0, 12'd0, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd1, 12'd1, 11'd2, 1'b0},
        '{gha_pkg::REQ_QUERY, 16'h0001, 10'd0, 12'd1, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b1, 10'd0, 12'd0, 11'd2, 1'b0},
        // wrong layer and generation zero never match
        '{gha_pkg::REQ_QUERY, 16'hFFFF, 10'd0, 12'd1, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd2, 1'b0},
        '{gha_pkg::REQ_QUERY, 16'h0001, 10'd0, 12'd0, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd2, 1'b0},
        '{gha_pkg::REQ_REMOVE, 16'h0001, 10'd1, 12'hFFF, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_INVALID, 1'b0, 10'd0, 12'd0, 11'd2, 1'b0},
        '{gha_pkg::REQ_REMOVE, 16'h0001, 10'd0, 12'd1, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd1, 1'b1},
        // crafted handle on a free slot with its current generation is valid
        '{gha_pkg::REQ_QUERY, 16'h0001, 10'd0, 12'd2, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b1, 10'd0, 12'd0, 11'd1, 1'b1},
        '{gha_pkg::REQ_REMOVE, 16'h0001, 10'd0, 12'd1, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_INVALID, 1'b0, 10'd0, 12'd0, 11'd1, 1'b1},
        '{gha_pkg::REQ_CREATE, 16'h0000, 10'd0, 12'd0, 1'b0, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd2, 11'd2, 1'b1},
        '{gha_pkg::REQ_CLEAN, 16'h0000, 10'd0, 12'd0, 1'b0, 1'b1,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd2, 1'b0},
        // clean a live slot, then the same slot again while it sits free
        '{gha_pkg::REQ_CLEAN, 16'h0000, 10'd1, 12'd0, 1'b1, 1'b0,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd1, 1'b0},
        '{gha_pkg::REQ_CLEAN, 16'h0000, 10'd1, 12'd0, 1'b1, 1'b1,
          1'b1, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        '{gha_pkg::REQ_CREATE, 16'h0000, 10'd0, 12'd0, 1'b0, 1'b0,
          1'b0, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        '{gha_pkg::REQ_CREATE, 16'h0000, 10'd0, 12'd0, 1'b0, 1'b0,
          1'b0, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        '{gha_pkg::REQ_CLEAN, 16'h0000, 10'h3FF, 12'd0, 1'b1, 1'b1,
          1'b0, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        '{gha_pkg::REQ_REMOVE, 16'h0000, 10'h3FF, 12'hFFF, 1'b1, 1'b1,
          1'b0, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        '{gha_pkg::REQ_QUERY, 16'h0001, 10'd2, 12'd1, 1'b0, 1'b0,
          1'b0, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0},
        // create ignores the handle fields
        '{gha_pkg::REQ_CREATE, 16'hFFFF, 10'h3FF, 12'hFFF, 1'b1, 1'b1,
          1'b0, gha_pkg::ST_OK, 1'b0, 10'd0, 12'd0, 11'd0, 1'b0}
    };

    function automatic bit handle_matches(input alloc_req_t r);
        if (r.layer != tag_q || r.index >= alloc_cnt)
            return 1'b0;
        return gen_mem[r.index] == {1'b0, r.gen};
    endfunction

    // Bump the generation; queue the slot at the tail unless it retires
    function automatic void bump_slot(input int unsigned idx);
        bit [GB:0] g;
        g = gen_mem[idx] + 1'b1;
        gen_mem[idx] = g;
        if (g == RETIRED)
            return;
        if (list_empty)
            free_head = idx;
        else
            next_mem[free_tail] = IB'(idx);
        free_tail  = idx;
        list_empty = 1'b0;
        if (free_cnt < SLOTS)
            free_cnt++;
    endfunction

    // Advance the table image by one request and return its result
    function automatic alloc_rsp_t allocator_step(input alloc_req_t r);
        alloc_rsp_t  o;
        int unsigned h;
        o = '0;
        o.status = gha_pkg::ST_OK;
        case (r.kind)
            gha_pkg::REQ_CREATE:
            begin
                if (!list_empty)
                begin
                    h = free_head;
                    o.new_index = IB'(h);
                    o.new_gen   = GB'(gen_mem[h]);
                    if (h == free_tail)
                        list_empty = 1'b1;
                    else
                        free_head = next_mem[h];
                    if (free_cnt > 0)
                        free_cnt--;
                end
                else if (alloc_cnt < SLOTS)
                begin
                    gen_mem[alloc_cnt] = 1;
                    o.new_index = IB'(alloc_cnt);
                    o.new_gen   = GB'(1);
                    alloc_cnt++;
                end
                else
                begin
                    o.status = gha_pkg::ST_FULL;
                end
            end
            gha_pkg::REQ_REMOVE:
            begin
                if (handle_matches(r))
                begin
                    bump_slot(r.index);
                    clean_due = 1'b1;
                end
                else
                begin
                    o.status = gha_pkg::ST_INVALID;
                end
            end
            gha_pkg::REQ_QUERY:
            begin
                o.is_valid = handle_matches(r);
            end
            default:
            begin
                if (r.clean_rm)
                begin
                    if (r.index >= alloc_cnt)
                        o.status = gha_pkg::ST_OUT_RANGE;
                    else if (gen_mem[r.index] < RETIRED)
                        bump_slot(r.index);
                end
                if (r.clean_end)
                    clean_due = 1'b0;
            end
        endcase
        o.used        = (IB + 1)'(alloc_cnt > free_cnt ? alloc_cnt - free_cnt : 0);
        o.needs_clean = clean_due;
        return o;
    endfunction

    // Mostly well-formed requests on handles handed out earlier, the rest noise
    function automatic alloc_req_t pick_request();
        alloc_req_t   r;
        slot_handle_t h;
        int unsigned  roll;
        r.kind      = gha_pkg::REQ_CREATE;
        r.layer     = LB'($urandom);
        r.index     = IB'($urandom);
        r.gen       = GB'($urandom);
        r.clean_rm  = 1'($urandom);
        r.clean_end = 1'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 28)
        begin
            r.kind = gha_pkg::REQ_CREATE;
        end
        else if (roll < 80 && issued.size() != 0)
        begin
            h = issued[$urandom_range(0, issued.size() - 1)];
            r.layer = tag_q;
            r.index = h.index;
            r.gen   = h.gen;
            if (roll < 55)
                r.kind = gha_pkg::REQ_REMOVE;
            else if (roll < 68)
                r.kind = gha_pkg::REQ_QUERY;
            else
            begin
                // damage one part of the handle
                r.kind = $urandom_range(0, 1) ? gha_pkg::REQ_REMOVE : gha_pkg::REQ_QUERY;
                case ($urandom_range(0, 2))
                    0:       r.layer = r.layer ^ (LB'(1) << $urandom_range(0, 15));
                    1:       r.gen   = r.gen ^ (GB'(1) << $urandom_range(0, GB - 1));
                    default: r.index = IB'($urandom);
                endcase
            end
        end
        else if (roll < 92)
        begin
            r.kind      = gha_pkg::REQ_CLEAN;
            r.index     = IB'($urandom_range(0, alloc_cnt));
            r.clean_rm  = ($urandom_range(0, 3) != 0);
            r.clean_end = ($urandom_range(0, 2) == 0);
        end
        else
        begin
            r.kind = gha_pkg::req_type_t'($urandom_range(0, 3));
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s got %0d want %0d", what, got, want);
    endtask

    // Drive one request, wait for it to be taken, then record its result
    task automatic issue(input alloc_req_t r, input alloc_rsp_t typed_rsp,
                         input bit pinned);
        alloc_rsp_t p;
        int         i;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.req_type          <= r.kind;
        req_ch.handle_layer      <= r.layer;
        req_ch.handle_index      <= r.index;
        req_ch.handle_generation <= r.gen;
        req_ch.clean_remove      <= r.clean_rm;
        req_ch.clean_last        <= r.clean_end;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        p = allocator_step(r);
        expected.push_back(pinned ? typed_rsp : p);
        // keep the list of handed-out handles roughly current
        if (r.kind == gha_pkg::REQ_CREATE && p.status == gha_pkg::ST_OK)
            issued.push_back(slot_handle_t'{p.new_index, p.new_gen});
        if ((r.kind == gha_pkg::REQ_REMOVE ||
             (r.kind == gha_pkg::REQ_CLEAN && r.clean_rm)) &&
            p.status == gha_pkg::ST_OK)
        begin
            for (i = issued.size() - 1; i >= 0; i--)
                if (issued[i].index == r.index)
                    issued.delete(i);
        end
    endtask

    // Drain outstanding results, let the pipe settle, then write the layer tag
    task automatic write_tag(input logic [LB-1:0] v);
        req_ch.valid <= 1'b0;
        while (expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tag_q = v;
    endtask

    task automatic random_run(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                idle_ok = ($urandom_range(0, 3) != 0);
            issue(pick_request(), '0, 1'b0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Score every result taken from the block
    always @(posedge clk)
    begin : score_rsp
        alloc_rsp_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected.size() == 0)
            begin
                note_mismatch("result with no request outstanding", 1, 0);
            end
            else
            begin
                want = expected.pop_front();
                if (rsp_ch.status !== want.status)
                    note_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.is_valid !== want.is_valid)
                    note_mismatch("is_valid", rsp_ch.is_valid, want.is_valid);
                if (rsp_ch.new_index !== want.new_index)
                    note_mismatch("new_index", rsp_ch.new_index, want.new_index);
                if (rsp_ch.new_generation !== want.new_gen)
                    note_mismatch("new_generation", rsp_ch.new_generation, want.new_gen);
                if (rsp_ch.used_count !== want.used)
                    note_mismatch("used_count", rsp_ch.used_count, want.used);
                if (rsp_ch.needs_clean !== want.needs_clean)
                    note_mismatch("needs_clean", rsp_ch.needs_clean, want.needs_clean);
            end
        end
    end

    // Stall the result channel in random bursts
    initial
    begin : rsp_stalls
        int unsigned stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    rsp_ch.ready <= 1'b1;
            end
            else if (idle_ok && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 13);
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_generational_handle_allocator: errors");
        $finish;
    end

    initial
    begin : stimulus
        alloc_req_t r;
        alloc_rsp_t w;
        int         k;
        rst_n                    <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_wdata                <= gha_pkg::LAYER_RESET;
        req_ch.valid             <= 1'b0;
        req_ch.req_type          <= gha_pkg::REQ_CREATE;
        req_ch.handle_layer      <= '0;
        req_ch.handle_index      <= '0;
        req_ch.handle_generation <= '0;
        req_ch.clean_remove      <= 1'b0;
        req_ch.clean_last        <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the opening table with the reset layer tag
        for (k = 0; k < N_OPENING; k++)
        begin
            r = '{opening[k].kind, opening[k].layer, opening[k].index, opening[k].gen,
                  opening[k].clean_rm, opening[k].clean_end};
            w = '{opening[k].st, opening[k].vld, opening[k].nidx, opening[k].ngen,
                  opening[k].used, opening[k].nc};
            issue(r, w, opening[k].pinned);
        end

        // small table, top layer tag
        write_tag(16'hFFFF);
        random_run(250);

        // a random layer tag from 2 to 65534
        write_tag(LB'($urandom_range(2, 65534)));
        random_run(240);

        // last stretch at full rate on both sides, reset layer tag
        write_tag(16'h0001);
        idle_ok = 1'b0;
        for (k = 0; k < 140; k++)
            issue(pick_request(), '0, 1'b0);

        req_ch.valid <= 1'b0;
        while (expected.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (errors == 0 && expected.size() == 0)
            $display("tb_generational_handle_allocator: clean");
        else
            $display("tb_generational_handle_allocator: errors");
        $finish;
    end

endmodule

/* generational_handle_allocator.f */
design/gha_pkg.sv
design/gha_if.sv
design/gha_ram.sv
design/generational_handle_allocator.sv
dv/tb_generational_handle_allocator.sv
